[rtl/sacl_pkg.sv]
// Shared types, codes and constants for the set-associative LRU cache tag store.
package sacl_pkg;

  localparam int ADDR_BITS   = 64;
  localparam int TAG_BITS    = 62;
  localparam int OPC_W       = 2;
  localparam int OUTC_W      = 2;
  localparam int WAYOUT_W    = 3;
  localparam int CNT_BITS    = 32;
  localparam int SIB_W       = 3;
  localparam int OFF_W       = 6;
  localparam int WAYS_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int SET_FIELD_W = (1 << SIB_W) - 1;

  localparam int DEF_NUM_SETS   = 64;
  localparam int DEF_MAX_WAYS   = 8;
  localparam int DEF_ADDR_WIDTH = 64;

  localparam logic [OPC_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPC_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_MODIFY = 2'd2;

  localparam logic [OUTC_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

  localparam logic [SIB_W-1:0]  RST_SET_INDEX_BITS = 3'd4;
  localparam logic [OFF_W-1:0]  RST_OFFSET_BITS    = 6'd4;
  localparam logic [WAYS_W-1:0] RST_WAYS_IN_USE    = 4'd1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic [OPC_W-1:0]     opcode;
  } access_t;

  typedef struct packed {
    logic [OUTC_W-1:0]   outcome;
    logic [WAYOUT_W-1:0] way_used;
    logic [CNT_BITS-1:0] hit_total;
    logic [CNT_BITS-1:0] miss_total;
    logic [CNT_BITS-1:0] eviction_total;
    logic                last_of_item;
  } result_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic read;
    logic eval;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic more;
  } ctrl_status_t;

endpackage

[rtl/sacl_ctrl.sv]
// Sequencer for the cache tag store: clear pass, read, evaluate, commit.
module sacl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  access_valid,
  output logic                  access_stall,
  input  sacl_pkg::ctrl_status_t status,
  output sacl_pkg::ctrl_cmd_t    cmd
);
  import sacl_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (access_valid) begin
          cmd.take   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = status.more ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign access_stall = (state != S_IDLE);

endmodule

[rtl/sacl_dpath.sv]
// Datapath: config registers, tag store memory, hit/victim logic, counters, result register.
module sacl_dpath #(
  parameter int NUM_SETS   = sacl_pkg::DEF_NUM_SETS,
  parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sacl_pkg::access_t                access,
  input  logic                             cfg_write,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  sacl_pkg::ctrl_cmd_t              cmd,
  output sacl_pkg::ctrl_status_t           status,
  output sacl_pkg::result_t                result,
  output logic                             result_valid,
  input  logic                             result_stall
);
  import sacl_pkg::*;

  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WIDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WEFF_W  = WAYS_W + 1;
  localparam int ENT_W   = 1 + TAG_BITS + AGE_W;
  localparam int ROW_W   = MAX_WAYS * ENT_W;
  localparam int MAP_N   = 1 << SET_FIELD_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  // configuration
  logic [SIB_W-1:0]  set_index_bits;
  logic [OFF_W-1:0]  offset_bits;
  logic [WAYS_W-1:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= RST_SET_INDEX_BITS;
      offset_bits    <= RST_OFFSET_BITS;
      ways_in_use    <= RST_WAYS_IN_USE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SET_INDEX_BITS: set_index_bits <= cfg_data[SIB_W-1:0];
        CFG_OFFSET_BITS:    offset_bits    <= cfg_data[OFF_W-1:0];
        CFG_WAYS_IN_USE:    ways_in_use    <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [ADDR_BITS-1:0]   addr_full;
  logic [ADDR_BITS-1:0]   above;
  logic [ADDR_BITS-1:0]   tag_full;
  logic [SET_FIELD_W-1:0] idx_mask;
  logic [SET_FIELD_W-1:0] set_raw;
  logic [SET_W-1:0]       set_map [MAP_N];

  for (genvar g = 0; g < MAP_N; g++) begin : g_set_map
    assign set_map[g] = SET_W'(g % NUM_SETS);
  end

  assign addr_full = ADDR_BITS'(access.address[ADDR_WIDTH-1:0]);
  assign above     = addr_full >> offset_bits;
  assign idx_mask  = SET_FIELD_W'((8'd1 << set_index_bits) - 8'd1);
  assign set_raw   = above[SET_FIELD_W-1:0] & idx_mask;
  assign tag_full  = above >> set_index_bits;

  logic [SET_W-1:0]    set_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                two_q;
  logic                pass_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      set_q <= set_map[set_raw];
      tag_q <= tag_full[TAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      two_q  <= 1'b0;
      pass_q <= 1'b0;
    end else if (cmd.take) begin
      two_q  <= (access.opcode == OP_MODIFY);
      pass_q <= 1'b0;
    end else if (cmd.commit) begin
      pass_q <= 1'b1;
    end
  end

  // tag store: one row per set
  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] row_q;
  logic [ROW_W-1:0] new_row;
  logic [SET_W-1:0] clr_cnt;
  logic             clear_last;

  assign clear_last = (clr_cnt == SET_W'(NUM_SETS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && !clear_last) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.commit) begin
      mem[set_q] <= new_row;
    end
    if (cmd.read) begin
      row_q <= mem[set_q];
    end
  end

  // row fields
  logic                rv [MAX_WAYS];
  logic [TAG_BITS-1:0] rt [MAX_WAYS];
  logic [AGE_W-1:0]    ra [MAX_WAYS];
  logic [MAX_WAYS-1:0] in_use;
  logic [WEFF_W-1:0]   ways_eff;

  always_comb begin
    if (ways_in_use == '0) begin
      ways_eff = WEFF_W'(1);
    end else if ({1'b0, ways_in_use} > WEFF_W'(MAX_WAYS)) begin
      ways_eff = WEFF_W'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_in_use};
    end
  end

  for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
    assign rv[w]     = row_q[w*ENT_W + ENT_W - 1];
    assign rt[w]     = row_q[w*ENT_W + AGE_W +: TAG_BITS];
    assign ra[w]     = row_q[w*ENT_W +: AGE_W];
    assign in_use[w] = (WEFF_W'(w) < ways_eff);
  end

  // evaluate: hit, free way or victim
  logic [OUTC_W-1:0] outcome_d;
  logic [WIDX_W-1:0] chosen_d;
  logic [OUTC_W-1:0] outcome_q;
  logic [WIDX_W-1:0] chosen_q;

  always_comb begin
    logic              hit_any;
    logic              free_any;
    logic [WIDX_W-1:0] hit_idx;
    logic [WIDX_W-1:0] free_idx;
    logic [WIDX_W-1:0] vic_idx;
    logic [AGE_W-1:0]  vic_age;
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && rv[w] && (rt[w] == tag_q)) begin
        hit_any = 1'b1;
        hit_idx = WIDX_W'(w);
      end
      if (in_use[w] && !rv[w]) begin
        free_any = 1'b1;
        free_idx = WIDX_W'(w);
      end
    end
    vic_idx = '0;
    vic_age = ra[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (ra[w] > vic_age)) begin
        vic_idx = WIDX_W'(w);
        vic_age = ra[w];
      end
    end
    if (hit_any) begin
      outcome_d = OUT_HIT;
      chosen_d  = hit_idx;
    end else if (free_any) begin
      outcome_d = OUT_FILL;
      chosen_d  = free_idx;
    end else begin
      outcome_d = OUT_EVICT;
      chosen_d  = vic_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      outcome_q <= outcome_d;
      chosen_q  <= chosen_d;
    end
  end

  // commit: new row with updated age ranks
  always_comb begin
    logic [AGE_W-1:0] hit_age;
    logic [AGE_W-1:0] age_k;
    hit_age = ra[chosen_q];
    new_row = row_q;
    for (int k = 0; k < MAX_WAYS; k++) begin
      age_k = ra[k];
      if (WIDX_W'(k) == chosen_q) begin
        new_row[k*ENT_W +: ENT_W] = {1'b1, tag_q, {AGE_W{1'b0}}};
      end else if (in_use[k] && rv[k] && ((outcome_q != OUT_HIT) || (age_k < hit_age))) begin
        if (age_k < AGE_MAX) begin
          new_row[k*ENT_W +: AGE_W] = age_k + AGE_W'(1);
        end
      end
    end
  end

  // counters and result register
  logic [CNT_BITS-1:0] hits;
  logic [CNT_BITS-1:0] misses;
  logic [CNT_BITS-1:0] evictions;
  logic [CNT_BITS-1:0] hits_next;
  logic [CNT_BITS-1:0] misses_next;
  logic [CNT_BITS-1:0] evictions_next;

  always_comb begin
    hits_next      = hits;
    misses_next    = misses;
    evictions_next = evictions;
    if (outcome_q == OUT_HIT) begin
      hits_next = (hits == '1) ? hits : hits + CNT_BITS'(1);
    end else begin
      misses_next = (misses == '1) ? misses : misses + CNT_BITS'(1);
    end
    if (outcome_q == OUT_EVICT) begin
      evictions_next = (evictions == '1) ? evictions : evictions + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits      <= '0;
      misses    <= '0;
      evictions <= '0;
    end else if (cmd.commit) begin
      hits      <= hits_next;
      misses    <= misses_next;
      evictions <= evictions_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.outcome        <= outcome_q;
      result.way_used       <= WAYOUT_W'(chosen_q);
      result.hit_total      <= hits_next;
      result.miss_total     <= misses_next;
      result.eviction_total <= evictions_next;
      result.last_of_item   <= !two_q || pass_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign status.clear_last = clear_last;
  assign status.out_free   = !result_valid || !result_stall;
  assign status.more       = two_q && !pass_q;

`ifndef ASSERT_OFF
  a_outcome_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.outcome == OUT_HIT || result.outcome == OUT_FILL ||
                      result.outcome == OUT_EVICT))
    else $error("illegal outcome code on result word");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.outcome == OUT_HIT) |-> (result.hit_total != '0))
    else $error("hit word with zero hit total");

  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.outcome != OUT_HIT) |-> (result.miss_total != '0))
    else $error("miss word with zero miss total");

  a_evict_le_miss: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.eviction_total <= result.miss_total))
    else $error("eviction total exceeds miss total");
`endif

endmodule

[rtl/set_assoc_cache_lru_sim_unit.sv]
// Result path: an accepted access word is registered, its tag row is read, evaluated and
// committed, and the result word is registered at commit. A modify word runs the read /
// evaluate / commit sequence twice (two results); no new access word is accepted meanwhile.
// A waiting result word does not block acceptance; commit holds while it waits.
// Reset: synchronous; a clearing pass over all NUM_SETS sets runs after reset,
// during which no access word is accepted (configuration writes still land).
module set_assoc_cache_lru_sim_unit #(
  parameter int NUM_SETS   = sacl_pkg::DEF_NUM_SETS,
  parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            access_valid,
  output logic                            access_stall,
  input  sacl_pkg::access_t               access,
  output logic                            result_valid,
  input  logic                            result_stall,
  output sacl_pkg::result_t               result,
  input  logic                            cfg_write,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sacl_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  sacl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_stall (access_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sacl_dpath #(
    .NUM_SETS   (NUM_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .access       (access),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
